/* hw/rtl/lcas_pkg.sv */
// Package for the load-cell averaging and stability unit: sizes, register
// indexes, opcodes, beat types and divider handshake types. No dependencies.
`timescale 1ns / 1ps

package lcas_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int WINDOW       = 8;

    // Derived sizes.
    localparam int CH_W   = 1;
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = 32 + $clog2(WINDOW);
    localparam int ADDR_W = CH_W + POS_W;
    localparam int DIFF_W = 25;
    localparam int HALF_W = 16;
    localparam int MUL_W  = DIFF_W + HALF_W + 1;
    localparam int PROD_W = 58;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDED     = 3'd7;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [31:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WEIGHT_MIN = 32'h8000_0000;
    localparam logic [7:0]  RUN_MAX    = 8'hFF;

    typedef struct packed {
        logic               opcode;
        logic               channel;
        logic signed [23:0] raw_sample;
    } t_in_item;

    typedef struct packed {
        logic               out_channel;
        logic               accepted;
        logic signed [31:0] average_weight;
        logic signed [31:0] stable_weight;
        logic               is_stable;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* hw/rtl/lcas_div.sv */
// Restoring divider, one quotient bit per cycle, for the fill-count average.
// Depends on lcas_pkg for widths and the request and response types.
`timescale 1ns / 1ps

module lcas_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcas_pkg::t_div_req i_req,
    output lcas_pkg::t_div_rsp o_rsp
);
    import lcas_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_divisor;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;

    logic [CNT_W:0]    n_rem_sh;
    logic              n_ge;
    logic [CNT_W:0]    n_rem;

    // The dividend shifts out of the top of r_quo while quotient bits enter
    // at the bottom.
    always_comb begin
        n_rem_sh = {r_rem, r_quo[SUM_W-1]};
        n_ge     = (n_rem_sh >= {1'b0, r_divisor});
        n_rem    = n_ge ? (n_rem_sh - {1'b0, r_divisor}) : n_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_step    <= STEP_W'(SUM_W - 1);
                r_divisor <= i_req.divisor;
                r_rem     <= '0;
                r_quo     <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_rem[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], n_ge};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hw/rtl/load_cell_average_stability_unit.sv */
// Top level of the load-cell averaging and stability unit: scaling, ring
// average, stability detector and sequencer. Depends on lcas_pkg and lcas_div.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  in        input      i_in_valid/o_in_stall   i_in_item (t_in_item)
//  out       output     o_out_valid/i_out_stall o_out_item (t_out_item)
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample beat passes through the split gain multiply, rounding and range check,
// the ring update, the one-bit-per-cycle fill-count divider, the stability step
// and the output load. A rejected sample goes from the range check straight to
// the output load, and a clear goes straight from acceptance to the output load.
// Reset is synchronous and active low; it clears the per-channel filter state and
// loads the register defaults, but not the ring. A stalled result holds only the next finish.

module load_cell_average_stability_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lcas_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lcas_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lcas_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import lcas_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_LO = 4'd1;
    localparam logic [3:0] S_MUL_HI = 4'd2;
    localparam logic [3:0] S_ROUND  = 4'd3;
    localparam logic [3:0] S_RANGE  = 4'd4;
    localparam logic [3:0] S_UPDATE = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_STAB   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);

    // Configuration registers.
    logic signed [23:0] r_offset [2];
    logic [31:0]        r_gain   [2];
    logic signed [31:0] r_min_weight;
    logic signed [31:0] r_max_weight;
    logic [30:0]        r_threshold;
    logic [7:0]         r_needed;

    // Per-channel filter state.
    logic [POS_W-1:0]        r_pos   [NUM_CHANNELS];
    logic                    r_full  [NUM_CHANNELS];
    logic signed [SUM_W-1:0] r_sum   [NUM_CHANNELS];
    logic signed [31:0]      r_prev  [NUM_CHANNELS];
    logic signed [31:0]      r_avg   [NUM_CHANNELS];
    logic [7:0]              r_run   [NUM_CHANNELS];
    logic                    r_flag  [NUM_CHANNELS];
    logic signed [31:0]      r_latch [NUM_CHANNELS];

    // Ring memory, one row of WINDOW entries per channel.
    logic [31:0] r_ring [2**ADDR_W];
    logic [31:0] r_ring_rd;

    // Sequencer and working registers.
    logic [3:0]               r_state;
    logic [CH_W-1:0]          r_ch;
    logic                     r_acc;
    logic                     r_zero;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [31:0]       r_weight;
    logic                     r_neg;
    logic signed [31:0]       r_avg_new;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_in_accept;
    logic                     w_chan_ok;
    logic [HALF_W-1:0]        w_half;
    logic signed [MUL_W-1:0]  w_mul;
    logic signed [PROD_W-1:0] w_rnd_sum;
    logic [ADDR_W-1:0]        w_addr;
    logic signed [PROD_W-1:0] n_prod_hi;
    logic signed [31:0]       n_weight;
    logic                     n_in_range;
    logic [POS_W-1:0]         n_pos;
    logic                     n_full;
    logic [CNT_W-1:0]         n_cnt;
    logic signed [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]         n_sum_mag;
    logic [SUM_W-1:0]         n_quo;
    logic signed [31:0]       n_avg;
    logic signed [32:0]       n_step;
    logic [32:0]              n_delta;
    logic                     n_small;
    logic [7:0]               n_run;
    t_out_item                n_out;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_chan_ok   = (int'(i_in_item.channel) < NUM_CHANNELS);
    assign w_addr      = {r_ch, r_pos[r_ch]};

    // One 25 x 17 signed multiplier serves both halves of the gain.
    assign w_half = (r_state == S_MUL_LO) ? r_gain[r_ch][HALF_W-1:0]
                                          : r_gain[r_ch][31:HALF_W];
    assign w_mul  = r_diff * $signed({1'b0, w_half});

    always_comb begin
        n_prod_hi = r_prod + (PROD_W'(w_mul) <<< HALF_W);

        // Round to nearest with ties upward, then saturate to 32 bits.
        w_rnd_sum = r_prod + ROUND_BIAS;
        if ((w_rnd_sum[PROD_W-1:47] == '0) || (w_rnd_sum[PROD_W-1:47] == '1)) begin
            n_weight = w_rnd_sum[47:16];
        end else begin
            n_weight = w_rnd_sum[PROD_W-1] ? WEIGHT_MIN : WEIGHT_MAX;
        end
        n_in_range = (r_weight >= r_min_weight) && (r_weight <= r_max_weight);

        // Ring bookkeeping: the oldest entry leaves the sum once the ring is full.
        n_pos  = (r_pos[r_ch] == POS_W'(WINDOW - 1)) ? '0 : (r_pos[r_ch] + 1'b1);
        n_full = r_full[r_ch] || (n_pos == '0);
        n_cnt  = n_full ? CNT_W'(WINDOW) : CNT_W'(n_pos);
        n_sum  = r_sum[r_ch]
               - (r_full[r_ch] ? SUM_W'($signed(r_ring_rd)) : SUM_W'(0))
               + SUM_W'(r_weight);
        n_sum_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);

        // The divider works on the magnitude; the sign goes back afterwards,
        // which truncates toward zero.
        n_quo = r_neg ? (~w_div_rsp.quotient + 1'b1) : w_div_rsp.quotient;
        n_avg = n_quo[31:0];

        n_step  = 33'(r_avg_new) - 33'(r_prev[r_ch]);
        n_delta = n_step[32] ? 33'(-n_step) : 33'(n_step);
        n_small = (n_delta < {2'b00, r_threshold});
        n_run   = (r_run[r_ch] == RUN_MAX) ? RUN_MAX : (r_run[r_ch] + 1'b1);

        n_out.out_channel    = r_ch;
        n_out.accepted       = r_acc;
        n_out.average_weight = r_zero ? 32'sd0 : r_avg[r_ch];
        n_out.stable_weight  = r_zero ? 32'sd0 : r_latch[r_ch];
        n_out.is_stable      = r_zero ? 1'b0   : r_flag[r_ch];
    end

    assign w_div_req.start    = (r_state == S_UPDATE);
    assign w_div_req.dividend = n_sum_mag;
    assign w_div_req.divisor  = n_cnt;

    lcas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Ring memory with a registered read port; the address is steady from
    // the first multiply cycle on, so the old entry is ready at the update.
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_ring[w_addr] <= r_weight;
        end
        r_ring_rd <= r_ring[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_offset[0]  <= '0;
            r_offset[1]  <= '0;
            r_gain[0]    <= 32'h0100_0000;
            r_gain[1]    <= 32'h0100_0000;
            r_min_weight <= WEIGHT_MIN;
            r_max_weight <= WEIGHT_MAX;
            r_threshold  <= 31'd256;
            r_needed     <= 8'd5;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pos[c]   <= '0;
                r_full[c]  <= 1'b0;
                r_sum[c]   <= '0;
                r_prev[c]  <= '0;
                r_avg[c]   <= '0;
                r_run[c]   <= '0;
                r_flag[c]  <= 1'b0;
                r_latch[c] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OFFSET_CH0: r_offset[0]  <= i_cfg_data[23:0];
                    CFG_OFFSET_CH1: r_offset[1]  <= i_cfg_data[23:0];
                    CFG_GAIN_CH0:   r_gain[0]    <= i_cfg_data;
                    CFG_GAIN_CH1:   r_gain[1]    <= i_cfg_data;
                    CFG_MIN_WEIGHT: r_min_weight <= i_cfg_data;
                    CFG_MAX_WEIGHT: r_max_weight <= i_cfg_data;
                    CFG_THRESHOLD:  r_threshold  <= i_cfg_data[30:0];
                    CFG_NEEDED:     r_needed     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // The output register fills at the end of an item and empties when
            // its beat is taken; both can happen at the same edge.
            if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_ch   <= i_in_item.channel;
                        r_acc  <= 1'b0;
                        r_zero <= !w_chan_ok;
                        r_diff <= DIFF_W'(i_in_item.raw_sample)
                                - DIFF_W'(r_offset[i_in_item.channel]);
                        if (!w_chan_ok) begin
                            r_state <= S_DONE;
                        end else if (i_in_item.opcode == OP_CLEAR) begin
                            r_pos[i_in_item.channel]   <= '0;
                            r_full[i_in_item.channel]  <= 1'b0;
                            r_sum[i_in_item.channel]   <= '0;
                            r_prev[i_in_item.channel]  <= '0;
                            r_avg[i_in_item.channel]   <= '0;
                            r_run[i_in_item.channel]   <= '0;
                            r_flag[i_in_item.channel]  <= 1'b0;
                            r_latch[i_in_item.channel] <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL_LO;
                        end
                    end
                end
                S_MUL_LO: begin
                    r_prod  <= PROD_W'(w_mul);
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_prod  <= n_prod_hi;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_weight <= n_weight;
                    r_state  <= S_RANGE;
                end
                S_RANGE: begin
                    r_state <= n_in_range ? S_UPDATE : S_DONE;
                end
                S_UPDATE: begin
                    r_sum[r_ch] <= n_sum;
                    r_pos[r_ch] <= n_pos;
                    r_full[r_ch] <= n_full;
                    r_neg       <= n_sum[SUM_W-1];
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_avg_new <= n_avg;
                        r_state   <= S_STAB;
                    end
                end
                S_STAB: begin
                    if (n_small) begin
                        r_run[r_ch] <= n_run;
                        if (n_run >= r_needed) begin
                            r_flag[r_ch]  <= 1'b1;
                            r_latch[r_ch] <= r_avg_new;
                        end
                    end else begin
                        r_run[r_ch]  <= '0;
                        r_flag[r_ch] <= 1'b0;
                    end
                    r_prev[r_ch] <= r_avg_new;
                    r_avg[r_ch]  <= r_avg_new;
                    r_acc        <= 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // Load the output register once it is empty or being taken.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the load-cell averaging and stability unit.
// Predicts every result beat from its own scaling, ring average and stability
// tracker; depends only on lcas_pkg and load_cell_average_stability_unit.
`timescale 1ns / 1ps

module testbench;

    import lcas_pkg::*;

    // All eight registers in one place, so a test can write a full setup.
    typedef struct packed {
        logic signed [23:0] off0;
        logic signed [23:0] off1;
        logic [31:0]        gain0;
        logic [31:0]        gain1;
        logic signed [31:0] min_w;
        logic signed [31:0] max_w;
        logic [30:0]        thresh;
        logic [7:0]         needed;
    } t_scale_setup;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Register mirror used by the weight predictor.
    logic signed [23:0] cfg_offset [2];
    logic [31:0]        cfg_gain [2];
    logic signed [31:0] cfg_min_w;
    logic signed [31:0] cfg_max_w;
    logic [30:0]        cfg_thresh;
    logic [7:0]         cfg_needed;

    // Per-channel filter state as the predictor sees it.
    logic signed [31:0]      ring_val [2][WINDOW];
    logic [POS_W-1:0]        fill_pos [2];
    logic                    is_full [2];
    logic signed [SUM_W-1:0] sum_acc [2];
    logic signed [31:0]      last_avg [2];
    logic signed [31:0]      cur_avg [2];
    logic [7:0]              calm_run [2];
    logic                    calm_flag [2];
    logic signed [31:0]      held_weight [2];

    // Stimulus state: the slowly wandering reading of each simulated cell.
    logic signed [23:0] drift_level [2];

    t_out_item   pending_reports [$];
    int unsigned mismatch_count  = 0;
    logic        idle_on         = 1'b1;
    int unsigned rx_hold_request = 0;
    int unsigned rx_hold_left    = 0;

    load_cell_average_stability_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Weight predictor
    // ------------------------------------------------------------------

    task automatic clear_channel_state(input int unsigned ch);
        fill_pos[ch]    = '0;
        is_full[ch]     = 1'b0;
        sum_acc[ch]     = '0;
        last_avg[ch]    = '0;
        cur_avg[ch]     = '0;
        calm_run[ch]    = '0;
        calm_flag[ch]   = 1'b0;
        held_weight[ch] = '0;
    endtask

    // Works out the result beat for one accepted input beat and updates the
    // predicted channel state.
    task automatic compute_weight_report(input t_in_item item, output t_out_item rep);
        int unsigned ch;
        int unsigned pos;
        longint      diff;
        longint      prod;
        longint      w;
        longint      cnt;
        longint      avg;
        longint      delta;
        ch = int'(item.channel);
        rep.out_channel = item.channel;
        rep.accepted    = 1'b0;
        if (item.opcode == OP_CLEAR) begin
            clear_channel_state(ch);
        end else begin
            diff = longint'($signed(item.raw_sample)) - longint'(cfg_offset[ch]);
            prod = diff * longint'(cfg_gain[ch]);
            // Q.24 to Q.8, round half up, then clamp to 32 bits signed.
            w = (prod + 64'sd32768) >>> 16;
            if (w > 64'sd2147483647) begin
                w = 64'sd2147483647;
            end else if (w < -64'sd2147483648) begin
                w = -64'sd2147483648;
            end
            if (w >= longint'(cfg_min_w) && w <= longint'(cfg_max_w)) begin
                pos = int'(fill_pos[ch]);
                if (is_full[ch]) begin
                    sum_acc[ch] = sum_acc[ch] - ring_val[ch][pos];
                end
                ring_val[ch][pos] = 32'(w);
                sum_acc[ch] = sum_acc[ch] + SUM_W'(w);
                pos = (pos + 1) % WINDOW;
                fill_pos[ch] = POS_W'(pos);
                if (pos == 0) begin
                    is_full[ch] = 1'b1;
                end
                cnt   = is_full[ch] ? longint'(WINDOW) : longint'(pos);
                avg   = longint'(sum_acc[ch]) / cnt;
                delta = avg - longint'(last_avg[ch]);
                if (delta < 0) begin
                    delta = -delta;
                end
                last_avg[ch] = 32'(avg);
                if (delta < longint'(cfg_thresh)) begin
                    if (calm_run[ch] != RUN_MAX) begin
                        calm_run[ch] = calm_run[ch] + 8'd1;
                    end
                    if (calm_run[ch] >= cfg_needed) begin
                        calm_flag[ch]   = 1'b1;
                        held_weight[ch] = 32'(avg);
                    end
                end else begin
                    calm_run[ch]  = '0;
                    calm_flag[ch] = 1'b0;
                end
                cur_avg[ch]  = 32'(avg);
                rep.accepted = 1'b1;
            end
        end
        rep.average_weight = cur_avg[ch];
        rep.stable_weight  = held_weight[ch];
        rep.is_stable      = calm_flag[ch];
    endtask

    // ------------------------------------------------------------------
    // Drivers. Every task here is entered and left just after a falling edge.
    // ------------------------------------------------------------------

    // Offers one beat until it is taken, records its expected result and
    // then maybe leaves a gap before the next one.
    task automatic send_beat(input t_in_item item);
        t_out_item   rep;
        int unsigned gap;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        compute_weight_report(item, rep);
        pending_reports.push_back(rep);
        @(negedge clk);
        gap = (idle_on && $urandom_range(99) < 33) ? $urandom_range(1, 8) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // The sender goes quiet until every expected result beat has come back.
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_OFFSET_CH0: cfg_offset[0] = data[23:0];
            CFG_OFFSET_CH1: cfg_offset[1] = data[23:0];
            CFG_GAIN_CH0:   cfg_gain[0]   = data;
            CFG_GAIN_CH1:   cfg_gain[1]   = data;
            CFG_MIN_WEIGHT: cfg_min_w     = data;
            CFG_MAX_WEIGHT: cfg_max_w     = data;
            CFG_THRESHOLD:  cfg_thresh    = data[30:0];
            CFG_NEEDED:     cfg_needed    = data[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Registers are to change only while the unit is idle, which the unit itself does not enforce, so drain first.
    task automatic apply_settings(input t_scale_setup s);
        drain_reports();
        write_reg(CFG_OFFSET_CH0, {{8{s.off0[23]}}, s.off0});
        write_reg(CFG_OFFSET_CH1, {{8{s.off1[23]}}, s.off1});
        write_reg(CFG_GAIN_CH0, s.gain0);
        write_reg(CFG_GAIN_CH1, s.gain1);
        write_reg(CFG_MIN_WEIGHT, s.min_w);
        write_reg(CFG_MAX_WEIGHT, s.max_w);
        write_reg(CFG_THRESHOLD, {1'b0, s.thresh});
        write_reg(CFG_NEEDED, {24'd0, s.needed});
        cfg_valid <= 1'b0;
    endtask

    function automatic t_scale_setup default_setup();
        t_scale_setup s;
        s.off0   = '0;
        s.off1   = '0;
        s.gain0  = 32'h0100_0000;
        s.gain1  = 32'h0100_0000;
        s.min_w  = WEIGHT_MIN;
        s.max_w  = WEIGHT_MAX;
        s.thresh = 31'd256;
        s.needed = 8'd5;
        return s;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom_range(32'h0100_0000);
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'h0100_0000;
            default: return $urandom_range(32'h0400_0000, 32'h0080_0000);
        endcase
    endfunction

    function automatic t_scale_setup pick_settings();
        t_scale_setup s;
        s.off0  = $urandom_range(1) ? 24'($urandom) : 24'sd0;
        s.off1  = $urandom_range(1) ? 24'($urandom) : 24'sd0;
        s.gain0 = pick_gain();
        s.gain1 = pick_gain();
        case ($urandom_range(3))
            0: begin
                s.min_w = WEIGHT_MIN;
                s.max_w = WEIGHT_MAX;
            end
            // Two random bounds, often an empty range.
            1: begin
                s.min_w = $urandom;
                s.max_w = $urandom;
            end
            2: begin
                s.min_w = -32'sd268435456;
                s.max_w = 32'sd268435456;
            end
            default: begin
                s.min_w = $urandom;
                s.max_w = WEIGHT_MAX;
            end
        endcase
        case ($urandom_range(4))
            0: s.thresh = '0;
            1: s.thresh = 31'($urandom_range(4096, 1));
            2: s.thresh = 31'd256;
            3: s.thresh = 31'($urandom);
            default: s.thresh = 31'h7FFF_FFFF;
        endcase
        case ($urandom_range(4))
            0: s.needed = 8'd0;
            1: s.needed = 8'd1;
            2: s.needed = 8'($urandom_range(8, 2));
            3: s.needed = RUN_MAX;
            default: s.needed = 8'($urandom);
        endcase
        return s;
    endfunction

    function automatic t_in_item sample_beat(input logic op, input logic ch,
                                             input logic signed [23:0] raw);
        t_in_item it;
        it.opcode     = op;
        it.channel    = ch;
        it.raw_sample = raw;
        return it;
    endfunction

    // Mostly small wander around each channel's level, so that stable runs
    // build up; now and then a jump, a clear or a wholly random reading.
    function automatic t_in_item make_sample(input int unsigned ch0_pct,
                                             input int unsigned clear_pct);
        t_in_item    it;
        int unsigned pick;
        it.opcode     = OP_SAMPLE;
        it.channel    = ($urandom_range(99) < ch0_pct) ? 1'b0 : 1'b1;
        it.raw_sample = 24'($urandom);
        pick = $urandom_range(99);
        if (pick < clear_pct) begin
            it.opcode = OP_CLEAR;
        end else if (pick < clear_pct + 8) begin
            drift_level[it.channel] = 24'($urandom);
            it.raw_sample = drift_level[it.channel];
        end else if (pick >= clear_pct + 14) begin
            it.raw_sample = drift_level[it.channel] + 24'($urandom_range(6)) - 24'sd3;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, a long hold-off on request, and the checker.
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            out_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            out_stall <= idle_on && ($urandom_range(99) < 33);
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with nothing expected, channel %0d",
                       out_item.out_channel);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (out_item.out_channel !== want.out_channel) begin
                    $error("out_channel: expected %0d, got %0d",
                           want.out_channel, out_item.out_channel);
                    mismatch_count++;
                end
                if (out_item.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d",
                           want.accepted, out_item.accepted);
                    mismatch_count++;
                end
                if (out_item.average_weight !== want.average_weight) begin
                    $error("average_weight: expected %0d, got %0d",
                           $signed(want.average_weight), $signed(out_item.average_weight));
                    mismatch_count++;
                end
                if (out_item.stable_weight !== want.stable_weight) begin
                    $error("stable_weight: expected %0d, got %0d",
                           $signed(want.stable_weight), $signed(out_item.stable_weight));
                    mismatch_count++;
                end
                if (out_item.is_stable !== want.is_stable) begin
                    $error("is_stable: expected %0d, got %0d",
                           want.is_stable, out_item.is_stable);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: a flat reading becomes stable after five steps, a
    // full-scale swing clears it, the ring wraps, and clears zero a channel.
    task automatic test_reset_defaults();
        repeat (5) send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sd0));
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sh7F_FFFF));
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sh80_0000));
        repeat (3) send_beat(sample_beat(OP_SAMPLE, 1'b1, 24'sd100));
        repeat (3) send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sd1));
        send_beat(sample_beat(OP_CLEAR, 1'b0, 24'($urandom)));
        send_beat(sample_beat(OP_CLEAR, 1'b1, 24'($urandom)));
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sd5));
    endtask

    // Saturation both ways, half-count rounding ties, zero gain with a zero
    // threshold and stable_needed of zero, and an empty valid range.
    task automatic test_scaling_extremes();
        t_scale_setup s;
        s = default_setup();
        s.off0   = 24'sh80_0000;
        s.off1   = 24'sh7F_FFFF;
        s.gain0  = 32'hFFFF_FFFF;
        s.gain1  = 32'hFFFF_FFFF;
        s.needed = 8'd1;
        apply_settings(s);
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sh7F_FFFF));
        send_beat(sample_beat(OP_SAMPLE, 1'b1, 24'sh80_0000));

        s = default_setup();
        s.gain0  = 32'h0000_8000;
        s.gain1  = 32'h0000_0000;
        s.thresh = '0;
        s.needed = 8'd0;
        apply_settings(s);
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sd1));
        send_beat(sample_beat(OP_SAMPLE, 1'b0, -24'sd1));
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sd3));
        send_beat(sample_beat(OP_SAMPLE, 1'b0, -24'sd3));
        send_beat(sample_beat(OP_SAMPLE, 1'b1, 24'sh7F_FFFF));

        s = default_setup();
        s.min_w = 32'sd1;
        s.max_w = 32'sd0;
        apply_settings(s);
        send_beat(sample_beat(OP_SAMPLE, 1'b0, 24'sd0));
        send_beat(sample_beat(OP_SAMPLE, 1'b1, 24'sd5));
    endtask

    task automatic test_random_settings();
        t_scale_setup s;
        for (int phase = 0; phase < 6; phase++) begin
            s = pick_settings();
            if (phase == 0) begin
                s.needed = 8'd0;
            end else if (phase == 1) begin
                s.thresh = '0;
            end
            apply_settings(s);
            repeat (110) send_beat(make_sample(50, 3));
        end
    endtask

    // The receiver holds off while beats keep coming, so the unit fills and
    // stalls its input; then the sender waits for every result to return.
    task automatic test_output_backpressure();
        apply_settings(default_setup());
        rx_hold_request = 400;
        repeat (24) send_beat(make_sample(50, 3));
        drain_reports();
        repeat (16) send_beat(make_sample(50, 3));
    endtask

    // A threshold no step can reach keeps every step stable, so the run
    // counter of channel 0 climbs to stable_needed of 255 and saturates there.
    // No idling at all in this stretch.
    task automatic test_stable_run_saturation();
        t_scale_setup s;
        s = default_setup();
        s.thresh = 31'h7FFF_FFFF;
        s.needed = RUN_MAX;
        apply_settings(s);
        idle_on = 1'b0;
        repeat (300) send_beat(make_sample(95, 0));
        drain_reports();
        idle_on = 1'b1;
    endtask

    initial begin
        cfg_offset[0] = '0;
        cfg_offset[1] = '0;
        cfg_gain[0]   = 32'h0100_0000;
        cfg_gain[1]   = 32'h0100_0000;
        cfg_min_w     = WEIGHT_MIN;
        cfg_max_w     = WEIGHT_MAX;
        cfg_thresh    = 31'd256;
        cfg_needed    = 8'd5;
        clear_channel_state(0);
        clear_channel_state(1);
        drift_level[0] = '0;
        drift_level[1] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_scaling_extremes();
        test_random_settings();
        test_output_backpressure();
        test_stable_run_saturation();

        drain_reports();
        repeat (60) @(negedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run of about a quarter of a millisecond.
    initial begin
        #(3_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
